FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the flame cell block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FHC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/fhc_pkg.sv
// ----------------------------------------------------------------------------
// Flame cell package
// Sizes, payload types and stage records shared by the flame cell block.
// ----------------------------------------------------------------------------
`default_nettype none

package fhc_pkg;

	// Number of cells in one pass of the strip.
	localparam int CELLS = 64;
	localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	typedef logic [IDX_W-1:0] idx_t;

	// Payload of one input request.
	typedef struct packed {
		logic [7:0] cooldown;
		logic [7:0] spark_add;
	} cell_in_t;

	// Payload of one result request.
	typedef struct packed {
		logic [7:0] heat;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_cell;
	} pix_out_t;

	// Heat handed from the update stage to the color stage.
	typedef struct packed {
		logic       valid;
		logic [7:0] heat;
		logic       last_cell;
	} heat_stage_t;

endpackage

`default_nettype wire

FILE: hdl/fhc_in_if.sv
// ----------------------------------------------------------------------------
// Flame cell input channel
// Valid/ready channel carrying the cooldown and spark of one cell.
// ----------------------------------------------------------------------------
`default_nettype none

interface fhc_in_if;

	logic              valid;
	logic              ready;
	fhc_pkg::cell_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

FILE: hdl/fhc_out_if.sv
// ----------------------------------------------------------------------------
// Flame cell output channel
// Valid/ready channel carrying the new heat and color of one cell.
// ----------------------------------------------------------------------------
`default_nettype none

interface fhc_out_if;

	logic              valid;
	logic              ready;
	fhc_pkg::pix_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

FILE: hdl/fhc_heat_mem.sv
// ----------------------------------------------------------------------------
// Flame cell heat store
// One heat byte per cell, one read and one write port, registered read data.
// Per-entry valid bits make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fhc_heat_mem (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  fhc_pkg::idx_t      rd_addr,
	output logic [7:0]         rd_data_s1,
	input  logic               wr_en,
	input  fhc_pkg::idx_t      wr_addr,
	input  logic [7:0]         wr_data
);

	logic [7:0]                 mem_q [fhc_pkg::CELLS];
	logic [fhc_pkg::CELLS-1:0]  vld_q;

	// Valid bits are cleared by reset and set by the first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Storage array and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= vld_q[rd_addr] ? mem_q[rd_addr] : 8'd0;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/fhc_color_stage.sv
// ----------------------------------------------------------------------------
// Flame cell color stage
// Maps a heat value to its red and green levels and holds the result request.
// ----------------------------------------------------------------------------
`default_nettype none

module fhc_color_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fhc_pkg::heat_stage_t stage_s2,
	output logic                 advance,
	fhc_out_if.source            pix_out
);

	localparam logic [7:0]  HEAT_SCALE = 8'd191;
	localparam logic [15:0] ROUND_HALF = 16'd127;
	localparam logic [7:0]  HOT_LIMIT  = 8'h80;
	localparam logic [7:0]  WARM_LIMIT = 8'h40;
	localparam logic [7:0]  FULL_RED   = 8'd255;
	localparam logic [7:0]  HOT_GREEN  = 8'd200;
	// 205 / 1024 stands in for 1/5 over the small ranges used here.
	localparam logic [7:0]  RECIP_5    = 8'd205;

	logic              valid_q;
	fhc_pkg::pix_out_t data_q;

	logic [15:0] scaled;
	logic [15:0] scaled_sum;
	logic [7:0]  tone;
	logic [7:0]  ramp;
	logic [17:0] warm_prod;
	logic [13:0] cool_prod;
	logic [7:0]  red_c;
	logic [7:0]  green_c;

	// The whole pipeline moves when this register is empty or being drained.
	assign advance = !valid_q || pix_out.ready;

	// Tone = round(heat * 191 / 255); division by 255 is exact as
	// (x + (x >> 8) + 1) >> 8 over this range.
	always_comb begin
		scaled     = 16'(stage_s2.heat) * 16'(HEAT_SCALE) + ROUND_HALF;
		scaled_sum = scaled + {8'd0, scaled[15:8]} + 16'd1;
		tone       = scaled_sum[15:8];
		ramp       = {tone[5:0], 2'b00};
		warm_prod  = 18'({ramp, 2'b00}) * 18'(RECIP_5);
		cool_prod  = 14'(tone[5:0]) * 14'(RECIP_5);
	end

	// Three bands of the palette: hot, warm and dim.
	always_comb begin
		if (tone > HOT_LIMIT) begin
			red_c   = FULL_RED;
			green_c = HOT_GREEN;
		end else if (tone > WARM_LIMIT) begin
			red_c   = FULL_RED;
			green_c = warm_prod[17:10];
		end else begin
			red_c   = ramp;
			green_c = {4'd0, cool_prod[13:10]};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= stage_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && stage_s2.valid) begin
			data_q.heat      <= stage_s2.heat;
			data_q.red       <= red_c;
			data_q.green     <= green_c;
			data_q.blue      <= 8'd0;
			data_q.last_cell <= stage_s2.last_cell;
		end
	end

	assign pix_out.valid = valid_q;
	assign pix_out.data  = data_q;

endmodule

`default_nettype wire

FILE: hdl/fire_heat_cell_stream_unit.sv
// ----------------------------------------------------------------------------
// Flame cell stream unit
// Per-cell flame update: cool, diffuse from the two previous cells, add the
// spark, store the new heat and map it to a color.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  cell_in   sink       valid / ready        cooldown, spark_add
//  pix_out   source     valid / ready        heat, red, green, blue, last_cell
//
//  One cell request is taken per clock, set by the single read-modify-write
//  pass over the heat store; the result then passes the stage 2 register
//  (update and write-back) and the output register (color map), which offers
//  it. Reset clears the heat store's valid bits at once; no clearing pass.
//  When the output is held, the whole pipeline holds and cell_in.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module fire_heat_cell_stream_unit (
	input  logic      clk,
	input  logic      arst_n,
	fhc_in_if.sink    cell_in,
	fhc_out_if.source pix_out
);

	localparam fhc_pkg::idx_t LAST_IDX = fhc_pkg::IDX_W'(fhc_pkg::CELLS - 1);
	localparam fhc_pkg::idx_t EDGE_IDX = fhc_pkg::IDX_W'(2);
	// 683 / 2048 stands in for 1/3 for sums up to 765.
	localparam logic [18:0]   RECIP_3  = 19'd683;

	logic                 advance;
	logic                 accept;
	fhc_pkg::idx_t        idx_q;

	logic                 valid_s1;
	logic [7:0]           cooldown_s1;
	logic [7:0]           spark_s1;
	logic                 first_s1;
	logic                 last_s1;
	fhc_pkg::idx_t        idx_s1;
	logic [7:0]           stored_s1;

	logic [7:0]           prev1_q;
	logic [7:0]           prev2_q;

	logic [7:0]           cooled;
	logic [9:0]           mix;
	logic [18:0]          mix_prod;
	logic [7:0]           base;
	logic [8:0]           sum;
	logic [7:0]           heat_new;
	logic                 wr_en;

	fhc_pkg::heat_stage_t stage_s2;

	assign cell_in.ready = advance;
	assign accept        = cell_in.valid && advance;

	// Cell position counter, wraps at the end of each pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + fhc_pkg::IDX_W'(1);
		end
	end

	// Heat store; an entry is rewritten long before its next read.
	fhc_heat_mem u_heat_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.rd_addr    (idx_q),
		.rd_data_s1 (stored_s1),
		.wr_en      (wr_en),
		.wr_addr    (idx_s1),
		.wr_data    (heat_new)
	);

	// Stage 1 request registers, filled alongside the store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= cell_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cooldown_s1 <= cell_in.data.cooldown;
			spark_s1    <= cell_in.data.spark_add;
			first_s1    <= idx_q < EDGE_IDX;
			last_s1     <= idx_q == LAST_IDX;
			idx_s1      <= idx_q;
		end
	end

	// Cool, diffuse from the two previous cooled values (not for the first two cells), then add the spark.
	always_comb begin
		cooled   = (cooldown_s1 > stored_s1) ? 8'd0 : stored_s1 - cooldown_s1;
		mix      = {2'b00, prev1_q} + {1'b0, prev2_q, 1'b0};
		mix_prod = 19'(mix) * RECIP_3;
		base     = first_s1 ? cooled : mix_prod[18:11];
		sum      = {1'b0, base} + {1'b0, spark_s1};
		heat_new = sum[8] ? 8'hFF : sum[7:0];
	end

	assign wr_en = advance && valid_s1;

	// Cooled values of the last two cells; reset clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev1_q <= 8'd0;
			prev2_q <= 8'd0;
		end else if (wr_en) begin
			prev2_q <= prev1_q;
			prev1_q <= cooled;
		end
	end

	// Stage 2 register feeding the color map.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s2 <= '0;
		end else if (advance) begin
			stage_s2.valid     <= valid_s1;
			stage_s2.heat      <= heat_new;
			stage_s2.last_cell <= last_s1;
		end
	end

	fhc_color_stage u_color_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_s2 (stage_s2),
		.advance  (advance),
		.pix_out  (pix_out)
	);

endmodule

`default_nettype wire

FILE: hdl/fhc_checker.sv
// ----------------------------------------------------------------------------
// Flame cell port checker
// Watches the ports of the flame cell unit for flow and palette slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fhc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input fhc_pkg::pix_out_t out_data
);

	// A held result stays offered.
	`FHC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// With the output register empty, the input must be ready.
	`FHC_ASSERT_IMPLY(a_in_free, clk, arst_n, !out_valid, in_ready, "input stalled with empty output")

	// Blue is never lit, and cold cells are dark.
	`FHC_ASSERT_IMPLY(a_cold_dark, clk, arst_n, out_valid, (out_data.blue == 8'd0) && ((out_data.heat != 8'd0) || ((out_data.red == 8'd0) && (out_data.green == 8'd0))), "wrong color for cold cell")

	// Full heat maps to the hot color.
	`FHC_ASSERT_IMPLY(a_full_hot, clk, arst_n, out_valid && (out_data.heat == 8'hFF), (out_data.red == 8'd255) && (out_data.green == 8'd200), "wrong color for full heat")

endmodule

bind fire_heat_cell_stream_unit fhc_checker u_fhc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (cell_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_data  (pix_out.data)
);

`default_nettype wire

FILE: verif/tb_fire_heat_cell_stream_unit.sv
// ----------------------------------------------------------------------------
// Flame cell stream unit testbench
// Streams cells through the flame update, predicts the new heat and color of
// every cell, and compares each result against the prediction.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fire_heat_cell_stream_unit;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF    = 4;
	localparam int CELL_TOTAL  = 1750;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 8;
	localparam int PRINT_LIMIT = 40;

	// Directed cells, {cooldown, spark_add}; they land on the first tick.
	localparam logic [15:0] DIRECTED_CELLS [25] = '{
		16'h00FF, 16'hFF00, 16'h0080, 16'h0001, 16'hFFFF,
		16'h00C8, 16'h0A40, 16'h5555, 16'hAAAA, 16'h0100,
		16'h8000, 16'h007F, 16'h00FE, 16'h3700, 16'h00A0,
		16'h0000, 16'h0063, 16'h00B0, 16'h0F0F, 16'hF0F0,
		16'h0020, 16'h00E0, 16'h0002, 16'h7F80, 16'h00FF
	};

	// Character of the random cells within one tick.
	typedef enum int {
		FLAVOR_EMBER,
		FLAVOR_BLAZE,
		FLAVOR_QUENCH,
		FLAVOR_NOISE
	} tick_flavor_e;

	// Receiver behavior over one run of cycles.
	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_PATTERN,
		READY_SCARCE
	} stall_mode_e;

	// Predicts the flame update and checks results in request order.
	class flame_scoreboard;
		logic [7:0]        heat_mem [fhc_pkg::CELLS];
		logic [7:0]        cooled_last;
		logic [7:0]        cooled_before;
		int                next_cell;
		fhc_pkg::pix_out_t expected_pixels [$];
		int                error_count;

		function new();
			foreach (heat_mem[i])
				heat_mem[i] = 8'd0;
			cooled_last   = 8'd0;
			cooled_before = 8'd0;
			next_cell     = 0;
			error_count   = 0;
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		task report_mismatch(input string what, input int got, input int want);
			if (error_count < PRINT_LIMIT)
				$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
			error_count++;
		endtask

		// Fills in the color of a heat value.
		function void heat_color(input int unsigned h, output logic [7:0] red,
			output logic [7:0] green);
			int unsigned t;
			int unsigned r;
			t = (h * 191 + 127) / 255;
			r = (t & 32'h3F) << 2;
			if (t > 32'h80) begin
				red   = 8'd255;
				green = 8'd200;
			end else if (t > 32'h40) begin
				red   = 8'd255;
				green = 8'((r * 4) / 5);
			end else begin
				red   = 8'(r);
				green = 8'(r / 20);
			end
		endfunction

		// Runs one cell through cool, diffuse and spark, and queues its pixel.
		function void note_cell(input fhc_pkg::cell_in_t c);
			int unsigned       stored;
			int unsigned       cooled;
			int unsigned       h;
			fhc_pkg::pix_out_t px;
			stored = heat_mem[next_cell];
			cooled = (c.cooldown > stored) ? 0 : stored - c.cooldown;
			if (next_cell >= 2)
				h = (cooled_last + 2 * cooled_before) / 3;
			else
				h = cooled;
			h = h + c.spark_add;
			if (h > 255)
				h = 255;
			heat_mem[next_cell] = 8'(h);
			cooled_before = cooled_last;
			cooled_last   = 8'(cooled);
			px.heat = 8'(h);
			heat_color(h, px.red, px.green);
			px.blue      = 8'd0;
			px.last_cell = (next_cell == fhc_pkg::CELLS - 1);
			expected_pixels.push_back(px);
			next_cell = (next_cell == fhc_pkg::CELLS - 1) ? 0 : next_cell + 1;
		endfunction

		// Compares one delivered pixel with the oldest expectation.
		task check_pixel(input fhc_pkg::pix_out_t got);
			fhc_pkg::pix_out_t want;
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected result, heat", got.heat, -1);
			end else begin
				want = expected_pixels.pop_front();
				if (got.heat !== want.heat)
					report_mismatch("heat", got.heat, want.heat);
				if (got.red !== want.red)
					report_mismatch("red", got.red, want.red);
				if (got.green !== want.green)
					report_mismatch("green", got.green, want.green);
				if (got.blue !== want.blue)
					report_mismatch("blue", got.blue, want.blue);
				if (got.last_cell !== want.last_cell)
					report_mismatch("last_cell", got.last_cell, want.last_cell);
			end
		endtask
	endclass

	logic            clk;
	logic            arst_n;
	int              cycle_count = 0;
	flame_scoreboard sb;

	fhc_in_if  cell_in ();
	fhc_out_if pix_out ();

	fire_heat_cell_stream_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cell_in (cell_in),
		.pix_out (pix_out)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Draws one random cell according to the flavor of its tick.
	function automatic fhc_pkg::cell_in_t make_cell(input tick_flavor_e flavor, input int pos);
		fhc_pkg::cell_in_t c;
		case (flavor)
			FLAVOR_EMBER: begin
				c.cooldown  = 8'($urandom_range(0, 10));
				c.spark_add = (pos < 7 && $urandom_range(0, 255) < 120) ?
					8'($urandom_range(160, 255)) : 8'd0;
			end
			FLAVOR_BLAZE: begin
				c.cooldown  = 8'($urandom_range(0, 20));
				c.spark_add = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
			end
			FLAVOR_QUENCH: begin
				c.cooldown  = 8'($urandom_range(30, 255));
				c.spark_add = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
			end
			default: begin
				c.cooldown  = 8'($urandom);
				c.spark_add = 8'($urandom);
			end
		endcase
		return c;
	endfunction

	// Presents one cell request and holds it until it is taken.
	task automatic send_cell(input fhc_pkg::cell_in_t c);
		cell_in.valid <= 1'b1;
		cell_in.data  <= c;
		@(posedge clk);
		while (!cell_in.ready)
			@(posedge clk);
	endtask

	// Every taken cell request feeds the predictor.
	always @(posedge clk) begin
		if (arst_n && cell_in.valid && cell_in.ready)
			sb.note_cell(cell_in.data);
	end

	// Every delivered result is checked.
	always @(posedge clk) begin
		if (arst_n && pix_out.valid && pix_out.ready)
			sb.check_pixel(pix_out.data);
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_fire_heat_cell_stream_unit: done, errors");
			$finish;
		end
	end

	// Receiver: runs of steady acceptance, coin flips, a fixed mask and heavy stalls.
	initial begin : drive_ready
		stall_mode_e mode;
		int          run_left;
		int          phase;
		logic [7:0]  mask;
		mode     = READY_ALWAYS;
		run_left = 0;
		phase    = 0;
		mask     = 8'hFF;
		pix_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (run_left == 0) begin
				mode     = stall_mode_e'($urandom_range(0, 3));
				run_left = $urandom_range(16, 96);
				mask     = 8'($urandom);
				phase    = 0;
			end
			run_left--;
			case (mode)
				READY_ALWAYS:  pix_out.ready <= 1'b1;
				READY_COIN:    pix_out.ready <= ($urandom_range(0, 1) == 1);
				READY_PATTERN: begin
					pix_out.ready <= mask[phase];
					phase = (phase + 1) % 8;
				end
				default:       pix_out.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Reset, stimulus, drain and verdict.
	initial begin : main_flow
		fhc_pkg::cell_in_t cells [$];
		fhc_pkg::cell_in_t c;
		tick_flavor_e      flavor;
		int                k;
		int                burst;
		int                gap;
		sb = new();
		arst_n        <= 1'b0;
		cell_in.valid <= 1'b0;
		cell_in.data  <= '0;

		// Directed cells first, then random ticks of varying character.
		foreach (DIRECTED_CELLS[i])
			cells.push_back(fhc_pkg::cell_in_t'(DIRECTED_CELLS[i]));
		flavor = FLAVOR_BLAZE;
		for (k = cells.size(); k < CELL_TOTAL; k++) begin
			if (k % fhc_pkg::CELLS == 0) begin
				gap = $urandom_range(0, 99);
				if (gap < 40)
					flavor = FLAVOR_EMBER;
				else if (gap < 70)
					flavor = FLAVOR_BLAZE;
				else if (gap < 85)
					flavor = FLAVOR_QUENCH;
				else
					flavor = FLAVOR_NOISE;
			end
			c = make_cell(flavor, k % fhc_pkg::CELLS);
			cells.push_back(c);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bursts of requests with random gaps; data is scrambled while idle.
		k = 0;
		while (k < cells.size()) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && k < cells.size()) begin
				send_cell(cells[k]);
				k++;
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cell_in.valid <= 1'b0;
				cell_in.data  <= fhc_pkg::cell_in_t'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
		cell_in.valid <= 1'b0;

		// Let the last taken request reach the predictor before waiting for the drain.
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sb.error_count == 0)
			$display("tb_fire_heat_cell_stream_unit: done, clean");
		else
			$display("tb_fire_heat_cell_stream_unit: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
